>>> design/clbs_pkg.sv
// Package: request codes, microcode word layout and the control program ROM.
`timescale 1ns / 1ps

package clbs_pkg;

	// Request codes on the func field
	localparam logic [1:0] FUNC_CMD    = 2'd0;
	localparam logic [1:0] FUNC_DATA   = 2'd1;
	localparam logic [1:0] FUNC_INIT   = 2'd2;
	localparam logic [1:0] FUNC_CURSOR = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_FOUR_BIT  = 2'd0;
	localparam logic [1:0] CFG_TWO_LINE  = 2'd1;
	localparam logic [1:0] CFG_TALL_FONT = 2'd2;
	localparam logic [1:0] CFG_COLUMNS   = 2'd3;

	// Program counter width and entry points
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] ENTRY_BYTE = 5'd0;
	localparam logic [PC_W-1:0] ENTRY_INIT = 5'd2;

	// Strobe phases: enable low, enable high, enable low with hold time
	localparam logic [1:0] PH_SETUP = 2'd0;
	localparam logic [1:0] PH_PULSE = 2'd1;
	localparam logic [1:0] PH_HOLD  = 2'd2;

	// Hold times in microseconds
	localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
	localparam logic [15:0] WAIT_EDGE     = 16'd1;
	localparam logic [15:0] WAIT_HOLD     = 16'd100;
	localparam logic [15:0] WAIT_4500     = 16'd4500;
	localparam logic [15:0] WAIT_150      = 16'd150;
	localparam logic [15:0] WAIT_2000     = 16'd2000;

	// Row address offset of the second line
	localparam logic [7:0] LINE2_OFFSET = 8'h40;

	// Step operation
	typedef enum logic [1:0] {
		OP_IDLE = 2'd0,  // single state, all pins low, power-up wait
		OP_RAW  = 2'd1,  // strobe the constant as is
		OP_HI   = 2'd2,  // strobe high nibble; skipped in 8-bit mode
		OP_LO   = 2'd3   // strobe low nibble, or whole byte in 8-bit mode
	} op_t;

	// Byte source for the step
	typedef enum logic [1:0] {
		SRC_REQ   = 2'd0,
		SRC_FSET  = 2'd1,
		SRC_CONST = 2'd2
	} src_t;

	// Extra hold added to the final state of a strobe
	typedef enum logic [2:0] {
		EX_NONE = 3'd0,
		EX_REQ  = 3'd1,  // 2000 us for clear and home commands
		EX_4500 = 3'd2,
		EX_150  = 3'd3,
		EX_2000 = 3'd4
	} extra_t;

	// Jump at the end of a step
	typedef enum logic [1:0] {
		JMP_NONE   = 2'd0,
		JMP_ALWAYS = 2'd1,
		JMP_EIGHT  = 2'd2   // taken in 8-bit mode
	} jump_t;

	typedef struct packed {
		op_t             op;
		src_t            src;
		logic [7:0]      konst;
		extra_t          extra;
		jump_t           jump;
		logic [PC_W-1:0] target;
		logic            last;
	} uword_t;

	function automatic uword_t uw(op_t op, src_t src, logic [7:0] konst, extra_t extra,
		jump_t jump, logic [PC_W-1:0] target, logic last);
		uword_t w;
		w.op     = op;
		w.src    = src;
		w.konst  = konst;
		w.extra  = extra;
		w.jump   = jump;
		w.target = target;
		w.last   = last;
		return w;
	endfunction

	// Control program
	function automatic uword_t rom_word(logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			// single byte request
			5'd0:  w = uw(OP_HI,   SRC_REQ,   8'h00, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd1:  w = uw(OP_LO,   SRC_REQ,   8'h00, EX_REQ,  JMP_NONE,   5'd0,  1'b1);
			// init: power-up wait, branch on bus width
			5'd2:  w = uw(OP_IDLE, SRC_CONST, 8'h00, EX_NONE, JMP_EIGHT,  5'd7,  1'b0);
			5'd3:  w = uw(OP_RAW,  SRC_CONST, 8'h03, EX_4500, JMP_NONE,   5'd0,  1'b0);
			5'd4:  w = uw(OP_RAW,  SRC_CONST, 8'h03, EX_4500, JMP_NONE,   5'd0,  1'b0);
			5'd5:  w = uw(OP_RAW,  SRC_CONST, 8'h03, EX_150,  JMP_NONE,   5'd0,  1'b0);
			5'd6:  w = uw(OP_RAW,  SRC_CONST, 8'h02, EX_NONE, JMP_ALWAYS, 5'd13, 1'b0);
			// 8-bit wake-up: function set three times
			5'd7:  w = uw(OP_HI,   SRC_FSET,  8'h00, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd8:  w = uw(OP_LO,   SRC_FSET,  8'h00, EX_4500, JMP_NONE,   5'd0,  1'b0);
			5'd9:  w = uw(OP_HI,   SRC_FSET,  8'h00, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd10: w = uw(OP_LO,   SRC_FSET,  8'h00, EX_150,  JMP_NONE,   5'd0,  1'b0);
			5'd11: w = uw(OP_HI,   SRC_FSET,  8'h00, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd12: w = uw(OP_LO,   SRC_FSET,  8'h00, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			// common tail: function set, display on, clear, entry mode
			5'd13: w = uw(OP_HI,   SRC_FSET,  8'h00, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd14: w = uw(OP_LO,   SRC_FSET,  8'h00, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd15: w = uw(OP_HI,   SRC_CONST, 8'h0C, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd16: w = uw(OP_LO,   SRC_CONST, 8'h0C, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd17: w = uw(OP_HI,   SRC_CONST, 8'h01, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd18: w = uw(OP_LO,   SRC_CONST, 8'h01, EX_2000, JMP_NONE,   5'd0,  1'b0);
			5'd19: w = uw(OP_HI,   SRC_CONST, 8'h06, EX_NONE, JMP_NONE,   5'd0,  1'b0);
			5'd20: w = uw(OP_LO,   SRC_CONST, 8'h06, EX_NONE, JMP_NONE,   5'd0,  1'b1);
			default: w = uw(OP_IDLE, SRC_CONST, 8'h00, EX_NONE, JMP_NONE, 5'd0,  1'b1);
		endcase
		return w;
	endfunction

endpackage

>>> design/char_lcd_bus_sequencer_top.sv
// Top level: microcoded character-LCD pin-state sequencer with stream ports.
//
//  Channel  Direction  Payload                                          Handshake
//  s_axis   in         tdata: func[1:0] value[9:2] column[17:10]         tvalid/tready
//                      row[25:18]
//  m_axis   out        tdata: reg_select[0] enable[1] data_pins[9:2]     tvalid/tready
//                      wait_us[25:10]; tlast marks the final state
//  cfg      in         cfg_we, cfg_addr, cfg_data                        write only
//
// One pin state leaves per clock while the output register drains; a high-nibble step
// in 8-bit mode is skipped and loads no pin state. A request is accepted first, then
// the ROM steps run in order from the entry point of the request.
// Reset sets the registers to 4-bit, two lines, small font, 16 columns, sequencer idle.
// A stall on m_axis freezes the step counter; s_tready rises once the last state is
// loaded, so the next request enters while that state still waits.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	// func, value, column, row from bit 0 up
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// reg_select, enable, data_pins, wait_us from bit 0 up
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [5:0]  cfg_data
);

	// configuration registers
	logic       four_bit_q;
	logic       two_line_q;
	logic       tall_font_q;
	logic [5:0] columns_q;

	// sequencer state
	logic                          busy_q;
	logic [clbs_pkg::PC_W-1:0]     pc_q;
	logic [1:0]                    phase_q;
	logic [7:0]                    req_byte_q;
	logic                          req_rs_q;
	logic                          req_long_q;

	// output register
	logic        out_valid_q;
	logic        out_rs_q;
	logic        out_en_q;
	logic [7:0]  out_data_q;
	logic [15:0] out_wait_q;
	logic        out_last_q;

	// request fields
	logic [1:0] in_func;
	logic [7:0] in_value;
	logic [7:0] in_column;
	logic [7:0] in_row;
	logic       accept;

	// cursor address
	logic [1:0] row_c;
	logic [1:0] row_max;
	logic [7:0] row_off;
	logic [7:0] addr_sum;
	logic [7:0] cursor_cmd;

	// step decode
	clbs_pkg::uword_t cw;
	logic [7:0]  fset;
	logic [7:0]  step_byte;
	logic        skip;
	logic        final_phase;
	logic        can_load;
	logic        go;
	logic [15:0] hold_wait;
	logic        st_rs;
	logic        st_en;
	logic [7:0]  st_data;
	logic [15:0] st_wait;
	logic [clbs_pkg::PC_W-1:0] pc_next;

	assign in_func   = s_axis_tdata[1:0];
	assign in_value  = s_axis_tdata[9:2];
	assign in_column = s_axis_tdata[17:10];
	assign in_row    = s_axis_tdata[25:18];

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && !busy_q;

	// clamp row to 3, then to the line count less one, and pick its offset
	always_comb begin
		row_c   = (in_row > 8'd3) ? 2'd3 : in_row[1:0];
		row_max = two_line_q ? 2'd1 : 2'd0;
		if (row_c > row_max) begin
			row_c = row_max;
		end
		case (row_c)
			2'd0:    row_off = 8'h00;
			2'd1:    row_off = clbs_pkg::LINE2_OFFSET;
			2'd2:    row_off = {2'b00, columns_q};
			default: row_off = clbs_pkg::LINE2_OFFSET + {2'b00, columns_q};
		endcase
		addr_sum   = in_column + row_off;
		cursor_cmd = {1'b1, addr_sum[6:0]};
	end

	// function set byte from the current configuration
	assign fset = {2'b00, 1'b1, !four_bit_q, two_line_q, !two_line_q && tall_font_q, 2'b00};

	// decode the current step
	assign cw = clbs_pkg::rom_word(pc_q);

	always_comb begin
		case (cw.src)
			clbs_pkg::SRC_REQ:  step_byte = req_byte_q;
			clbs_pkg::SRC_FSET: step_byte = fset;
			default:            step_byte = cw.konst;
		endcase

		case (cw.extra)
			clbs_pkg::EX_REQ:
				hold_wait = clbs_pkg::WAIT_HOLD + (req_long_q ? clbs_pkg::WAIT_2000 : 16'd0);
			clbs_pkg::EX_4500: hold_wait = clbs_pkg::WAIT_HOLD + clbs_pkg::WAIT_4500;
			clbs_pkg::EX_150:  hold_wait = clbs_pkg::WAIT_HOLD + clbs_pkg::WAIT_150;
			clbs_pkg::EX_2000: hold_wait = clbs_pkg::WAIT_HOLD + clbs_pkg::WAIT_2000;
			default:           hold_wait = clbs_pkg::WAIT_HOLD;
		endcase

		skip        = (cw.op == clbs_pkg::OP_HI) && !four_bit_q;
		final_phase = skip || (cw.op == clbs_pkg::OP_IDLE) || (phase_q == clbs_pkg::PH_HOLD);

		st_rs   = 1'b0;
		st_en   = (phase_q == clbs_pkg::PH_PULSE);
		st_wait = (phase_q == clbs_pkg::PH_HOLD) ? hold_wait : clbs_pkg::WAIT_EDGE;
		case (cw.op)
			clbs_pkg::OP_IDLE: begin
				st_data = 8'h00;
				st_en   = 1'b0;
				st_wait = clbs_pkg::WAIT_POWER_UP;
			end
			clbs_pkg::OP_RAW: begin
				st_data = cw.konst;
			end
			clbs_pkg::OP_HI: begin
				st_data = {4'h0, step_byte[7:4]};
				st_rs   = (cw.src == clbs_pkg::SRC_REQ) && req_rs_q;
			end
			default: begin
				st_data = four_bit_q ? {4'h0, step_byte[3:0]} : step_byte;
				st_rs   = (cw.src == clbs_pkg::SRC_REQ) && req_rs_q;
			end
		endcase

		case (cw.jump)
			clbs_pkg::JMP_ALWAYS: pc_next = cw.target;
			clbs_pkg::JMP_EIGHT:  pc_next = four_bit_q ? pc_q + 1'b1 : cw.target;
			default:              pc_next = pc_q + 1'b1;
		endcase
	end

	assign can_load = !out_valid_q || m_axis_tready;
	assign go       = busy_q && can_load;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q  <= 1'b1;
			two_line_q  <= 1'b1;
			tall_font_q <= 1'b0;
			columns_q   <= 6'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				clbs_pkg::CFG_FOUR_BIT:  four_bit_q  <= cfg_data[0];
				clbs_pkg::CFG_TWO_LINE:  two_line_q  <= cfg_data[0];
				clbs_pkg::CFG_TALL_FONT: tall_font_q <= cfg_data[0];
				default:                 columns_q   <= cfg_data;
			endcase
		end
	end

	// step counter and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pc_q    <= clbs_pkg::ENTRY_BYTE;
			phase_q <= clbs_pkg::PH_SETUP;
		end else if (accept) begin
			busy_q  <= 1'b1;
			pc_q    <= (in_func == clbs_pkg::FUNC_INIT) ? clbs_pkg::ENTRY_INIT
				: clbs_pkg::ENTRY_BYTE;
			phase_q <= clbs_pkg::PH_SETUP;
		end else if (go) begin
			if (final_phase) begin
				phase_q <= clbs_pkg::PH_SETUP;
				if (cw.last) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_next;
				end
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	// latch the request byte and its flags
	always_ff @(posedge clk) begin
		if (accept) begin
			req_byte_q <= (in_func == clbs_pkg::FUNC_CURSOR) ? cursor_cmd : in_value;
			req_rs_q   <= (in_func == clbs_pkg::FUNC_DATA);
			req_long_q <= (in_func == clbs_pkg::FUNC_CMD) && (in_value inside {[8'd1:8'd3]});
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && !skip) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the pin state
	always_ff @(posedge clk) begin
		if (go && !skip) begin
			out_rs_q   <= st_rs;
			out_en_q   <= st_en;
			out_data_q <= st_data;
			out_wait_q <= st_wait;
			out_last_q <= cw.last && final_phase;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_wait_q, out_data_q, out_en_q, out_rs_q};

endmodule
